// ===== design/emboss_bump_shade_macros.svh =====
// Assertion macros used by the checker file.
`ifndef EMBOSS_BUMP_SHADE_MACROS_SVH
`define EMBOSS_BUMP_SHADE_MACROS_SVH
`define EBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/ebs_pkg.sv =====
// Package with the types and constants of the emboss shader.
`default_nettype none
package ebs_pkg;
    localparam int GrayW  = 8;
    localparam int LightW = 9;
    localparam int LzW    = 8;
    localparam int NzW    = 11;
    localparam int CfgW   = 11;
    localparam int CfgIdxW = 2;
    localparam int GradW  = 11;   // signed, |g| <= 765
    localparam int DotW   = 22;   // signed dot product
    localparam int LenW   = 24;   // nx^2+ny^2+nz^2 < 2^23, kept to an even width
    localparam int RootW  = 12;   // root < 2^12
    localparam int QW     = 9;    // quotient bits (clamped to 255 beyond)
    localparam int SqrtSteps = RootW;
    localparam int DivSteps  = QW;

    localparam logic [CfgIdxW-1:0] RegLightX = 2'd0;
    localparam logic [CfgIdxW-1:0] RegLightY = 2'd1;
    localparam logic [CfgIdxW-1:0] RegLightZ = 2'd2;
    localparam logic [CfgIdxW-1:0] RegSurfNz = 2'd3;

    // Flags travelling with each pixel down the chain.
    typedef struct packed {
        logic flat;
        logic negative;
    } t_flags;

    typedef struct packed {
        logic              valid;
        t_flags            flags;
        logic [LzW-1:0]    lz;
        logic [DotW-2:0]   dot;    // non-negative dot once sign is removed
        logic [LenW-1:0]   rem;    // square root remainder
        logic [RootW-1:0]  root;
        logic [LenW-1:0]   val;    // radicand being consumed
    } t_sq_cell;

    typedef struct packed {
        logic              valid;
        t_flags            flags;
        logic [LzW-1:0]    lz;
        logic [RootW-1:0]  root;
        logic [DotW+RootW-1:0] prem; // partial remainder
        logic [QW-1:0]     quo;
    } t_dv_cell;
endpackage
`default_nettype wire

// ===== design/ebs_stream_if.sv =====
// Valid/ready stream interfaces for neighbourhood and shade beats.
`default_nettype none
interface ebs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_up_left;
    logic [7:0] gray_up;
    logic [7:0] gray_up_right;
    logic [7:0] gray_left;
    logic [7:0] gray_right;
    logic [7:0] gray_down_left;
    logic [7:0] gray_down;
    logic [7:0] gray_down_right;
    modport source (output valid, gray_up_left, gray_up, gray_up_right, gray_left,
        gray_right, gray_down_left, gray_down, gray_down_right, input ready);
    modport sink (input valid, gray_up_left, gray_up, gray_up_right, gray_left,
        gray_right, gray_down_left, gray_down, gray_down_right, output ready);
endinterface

interface ebs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] shade;
    modport source (output valid, shade, input ready);
    modport sink (input valid, shade, output ready);
endinterface
`default_nettype wire

// ===== design/ebs_sqrt_cell.sv =====
// One restoring square root step: settles one root bit per cell.
`default_nettype none
module ebs_sqrt_cell
    import ebs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_sq_cell i_cell,
    output t_sq_cell      o_cell
);
    logic [LenW+1:0] w_rem;
    logic [LenW+1:0] w_trial;
    t_sq_cell        n_cell;
    t_sq_cell        r_cell;

    always_comb begin
        // Bring down the next two radicand bits and try root*4+1.
        w_rem   = {i_cell.rem, i_cell.val[LenW-1 -: 2]};
        w_trial = {{(LenW-RootW){1'b0}}, i_cell.root, 2'b01};
        n_cell     = i_cell;
        n_cell.val = {i_cell.val[LenW-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_cell.rem  = LenW'(w_rem - w_trial);
            n_cell.root = {i_cell.root[RootW-2:0], 1'b1};
        end else begin
            n_cell.rem  = LenW'(w_rem);
            n_cell.root = {i_cell.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.flags <= n_cell.flags;
            r_cell.lz    <= n_cell.lz;
            r_cell.dot   <= n_cell.dot;
            r_cell.rem   <= n_cell.rem;
            r_cell.root  <= n_cell.root;
            r_cell.val   <= n_cell.val;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ===== design/ebs_div_cell.sv =====
// One restoring division step: settles one quotient bit per cell.
`default_nettype none
module ebs_div_cell
    import ebs_pkg::*;
#(
    parameter int Step = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_dv_cell i_cell,
    output t_dv_cell      o_cell
);
    localparam int Shift = QW - 1 - Step;
    logic [DotW+RootW-1:0] w_div;
    t_dv_cell              n_cell;
    t_dv_cell              r_cell;

    always_comb begin
        w_div  = (DotW+RootW)'(i_cell.root) << Shift;
        n_cell = i_cell;
        if (i_cell.prem >= w_div) begin
            n_cell.prem = i_cell.prem - w_div;
            n_cell.quo  = {i_cell.quo[QW-2:0], 1'b1};
        end else begin
            n_cell.quo  = {i_cell.quo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.flags <= n_cell.flags;
            r_cell.lz    <= n_cell.lz;
            r_cell.root  <= n_cell.root;
            r_cell.prem  <= n_cell.prem;
            r_cell.quo   <= n_cell.quo;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ===== design/emboss_bump_shade.sv =====
// Top level of the emboss shader: gradient, dot product, root and divide chains.
// Usage: each input beat carries the eight grayscale neighbours of one pixel;
// each output beat carries its 8-bit shade, one output beat per input beat,
// in order. Light vector and surface nz are set through the write port
// (index 0 light_x, 1 light_y, 2 light_z, 3 surface_nz); the user must write
// them only while the block is idle; the block does not enforce it.
// Throughput: one pixel per clock while the receiver takes each output beat.
// Chain order: gradients, products and squares, sums, twelve square root
// cells, nine divide cells, then the output register. The whole chain
// advances as one; when the receiver stalls with the output register full,
// the chain freezes and input ready falls, so no beat is lost. Reset clears
// all valid bits and loads the default light vector; no clearing pass is needed.
`default_nettype none
module emboss_bump_shade
    import ebs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data,
    ebs_in_if.sink               s_in,
    ebs_out_if.source            m_out
);
    logic signed [LightW-1:0] r_lx, r_ly;
    logic [LzW-1:0]           r_lz;
    logic [NzW-1:0]           r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= LightW'(212);
            r_ly <= '0;
            r_lz <= LzW'(142);
            r_nz <= NzW'(153);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegLightX: r_lx <= i_cfg_data[LightW-1:0];
                RegLightY: r_ly <= i_cfg_data[LightW-1:0];
                RegLightZ: r_lz <= i_cfg_data[LzW-1:0];
                RegSurfNz: r_nz <= i_cfg_data[NzW-1:0];
                default: ;
            endcase
        end
    end

    logic w_adv;
    logic r_ov;
    logic [7:0] r_shade;
    assign w_adv       = !r_ov || m_out.ready;
    assign s_in.ready  = w_adv;

    // Stage 1: gradients.
    logic r1_v;
    logic signed [GradW-1:0] r1_nx, r1_ny;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_adv) r1_v <= s_in.valid;
        if (w_adv) begin
            r1_nx <= GradW'(s_in.gray_up_left) + GradW'(s_in.gray_left)
                   + GradW'(s_in.gray_down_left) - GradW'(s_in.gray_up_right)
                   - GradW'(s_in.gray_right) - GradW'(s_in.gray_down_right);
            r1_ny <= GradW'(s_in.gray_down_left) + GradW'(s_in.gray_down)
                   + GradW'(s_in.gray_down_right) - GradW'(s_in.gray_up_left)
                   - GradW'(s_in.gray_up) - GradW'(s_in.gray_up_right);
        end
    end

    // Stage 2: products and squares, one multiplier each.
    logic r2_v, r2_flat;
    logic signed [DotW-1:0] r2_px, r2_py, r2_pz;
    logic [LenW-1:0] r2_sx, r2_sy, r2_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_adv) r2_v <= r1_v;
        if (w_adv) begin
            r2_flat <= (r1_nx == '0) && (r1_ny == '0);
            r2_px <= DotW'(r1_nx * r_lx);
            r2_py <= DotW'(r1_ny * r_ly);
            r2_pz <= DotW'($signed({1'b0, r_nz}) * $signed({1'b0, r_lz}));
            r2_sx <= LenW'(r1_nx * r1_nx);
            r2_sy <= LenW'(r1_ny * r1_ny);
            r2_sz <= LenW'(r_nz * r_nz);
        end
    end

    // Stage 3: sums.
    logic signed [DotW-1:0] w_dot;
    t_sq_cell w_sq_head;
    assign w_dot = r2_px + r2_py + r2_pz;
    t_sq_cell r3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3.valid <= 1'b0;
        else if (w_adv) r3.valid <= r2_v;
        if (w_adv) begin
            r3.flags.flat     <= r2_flat;
            r3.flags.negative <= w_dot[DotW-1];
            r3.lz   <= r_lz;
            r3.dot  <= w_dot[DotW-2:0];
            r3.rem  <= '0;
            r3.root <= '0;
            r3.val  <= r2_sx + r2_sy + r2_sz;
        end
    end
    assign w_sq_head = r3;

    t_sq_cell w_sq [SqrtSteps+1];
    assign w_sq[0] = w_sq_head;
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sq
        ebs_sqrt_cell u_cell (.i_clk, .i_rst_n, .i_en(w_adv),
            .i_cell(w_sq[k]), .o_cell(w_sq[k+1]));
    end

    t_dv_cell w_dv [DivSteps+1];
    always_comb begin
        w_dv[0].valid = w_sq[SqrtSteps].valid;
        w_dv[0].flags = w_sq[SqrtSteps].flags;
        w_dv[0].lz    = w_sq[SqrtSteps].lz;
        w_dv[0].root  = w_sq[SqrtSteps].root;
        w_dv[0].prem  = (DotW+RootW)'(w_sq[SqrtSteps].dot);
        w_dv[0].quo   = '0;
    end
    for (genvar k = 0; k < DivSteps; k++) begin : g_dv
        ebs_div_cell #(.Step(k)) u_cell (.i_clk, .i_rst_n, .i_en(w_adv),
            .i_cell(w_dv[k]), .o_cell(w_dv[k+1]));
    end

    // Final selection and saturation. Quotient overflow beyond the cells leaves
    // at least one root in the remainder.
    t_dv_cell w_t;
    logic [7:0] w_shade;
    assign w_t = w_dv[DivSteps];
    always_comb begin
        if (w_t.flags.flat)                      w_shade = w_t.lz;
        else if (w_t.flags.negative)             w_shade = 8'd0;
        else if (w_t.root == '0)                 w_shade = 8'd255;
        else if (w_t.quo[QW-1] ||
                 w_t.prem >= ((DotW+RootW)'(w_t.root) << QW)) w_shade = 8'd255;
        else                                     w_shade = w_t.quo[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= w_t.valid;
        if (w_adv) r_shade <= w_shade;
    end

    assign m_out.valid = r_ov;
    assign m_out.shade = r_shade;
endmodule
`default_nettype wire

// ===== design/ebs_checker.sv =====
// Port-level checker for the emboss shader, bound to the top level.
`default_nettype none
`include "emboss_bump_shade_macros.svh"
module ebs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_shade
);
    `EBS_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "output beat dropped")
    `EBS_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_shade), "stalled shade changed")
    `EBS_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")
    `EBS_ASSERT_IMPL(a_ready_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "input taken while chain frozen")
endmodule

bind emboss_bump_shade ebs_checker u_ebs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_shade(m_out.shade));
`default_nettype wire
